// ===== sv/kvp_pkg.sv =====
// Shared types and constants for the command line parser.
package kvp_pkg;

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_G      = 4'd1,
    ST_GE     = 4'd2,
    ST_S      = 4'd3,
    ST_SE     = 4'd4,
    ST_SET    = 4'd5,
    ST_D      = 4'd6,
    ST_DE     = 4'd7,
    ST_TYPED  = 4'd8,
    ST_KEY    = 4'd9,
    ST_SKEY   = 4'd10,
    ST_SBLANK = 4'd11,
    ST_SVALUE = 4'd12,
    ST_CR     = 4'd13
  } parser_state_t;

  typedef enum logic [1:0] {
    STAT_MORE = 2'd0,
    STAT_BAD  = 2'd1,
    STAT_GOOD = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CODE_GET = 2'd0,
    CODE_SET = 2'd1,
    CODE_DEL = 2'd2
  } type_code_t;

  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    status_t    status;
    logic       type_write;
    type_code_t type_code;
    logic       key_append;
    logic       value_append;
    logic [7:0] byte_out;
  } kvp_result_t;

endpackage

// ===== sv/kvp_if.sv =====
// Valid/ready channel interfaces for parser input bytes and parser results.
interface kvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       restart;

  modport source (output valid, output byte_in, output restart, input ready);
  modport sink (input valid, input byte_in, input restart, output ready);
endinterface

interface kvp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       type_write;
  logic [1:0] type_code;
  logic       key_append;
  logic       value_append;
  logic [7:0] byte_out;

  modport source (output valid, output status, output type_write, output type_code,
                  output key_append, output value_append, output byte_out, input ready);
  modport sink (input valid, input status, input type_write, input type_code,
                input key_append, input value_append, input byte_out, output ready);
endinterface

// ===== sv/kvp_step.sv =====
// Next parser position and per-byte result for one input byte.
module kvp_step (
  input  kvp_pkg::parser_state_t state,
  input  logic [7:0]             byte_in,
  input  logic                   restart,
  output kvp_pkg::parser_state_t state_next,
  output kvp_pkg::kvp_result_t   result
);

  kvp_pkg::parser_state_t st;
  kvp_pkg::status_t       status;
  kvp_pkg::type_code_t    tc;
  logic                   tw;
  logic                   ka;
  logic                   va;
  logic                   blank;
  logic                   eol;

  assign blank = (byte_in == kvp_pkg::CH_SPACE) || (byte_in == kvp_pkg::CH_TAB);
  assign eol   = (byte_in == kvp_pkg::CH_CR) || (byte_in == kvp_pkg::CH_LF);

  always_comb begin
    st     = restart ? kvp_pkg::ST_START : state;
    status = kvp_pkg::STAT_MORE;
    tw     = 1'b0;
    tc     = kvp_pkg::CODE_GET;
    ka     = 1'b0;
    va     = 1'b0;
    unique case (st)
      kvp_pkg::ST_START: begin
        if (blank) begin
        end else if (byte_in == kvp_pkg::CH_G) st = kvp_pkg::ST_G;
        else if (byte_in == kvp_pkg::CH_S) st = kvp_pkg::ST_S;
        else if (byte_in == kvp_pkg::CH_D) st = kvp_pkg::ST_D;
        else status = kvp_pkg::STAT_BAD;
      end
      kvp_pkg::ST_G: begin
        if (byte_in == kvp_pkg::CH_E) st = kvp_pkg::ST_GE;
        else status = kvp_pkg::STAT_BAD;
      end
      kvp_pkg::ST_GE: begin
        if (byte_in == kvp_pkg::CH_T) begin
          st = kvp_pkg::ST_TYPED;
          tw = 1'b1;
          tc = kvp_pkg::CODE_GET;
        end else status = kvp_pkg::STAT_BAD;
      end
      kvp_pkg::ST_S: begin
        if (byte_in == kvp_pkg::CH_E) st = kvp_pkg::ST_SE;
        else status = kvp_pkg::STAT_BAD;
      end
      kvp_pkg::ST_SE: begin
        if (byte_in == kvp_pkg::CH_T) begin
          st = kvp_pkg::ST_SET;
          tw = 1'b1;
          tc = kvp_pkg::CODE_SET;
        end else status = kvp_pkg::STAT_BAD;
      end
      kvp_pkg::ST_SET: begin
        // Any non-blank, line ends included, opens the key.
        if (!blank) begin
          ka = 1'b1;
          st = kvp_pkg::ST_SKEY;
        end
      end
      kvp_pkg::ST_D: begin
        if (byte_in == kvp_pkg::CH_E) st = kvp_pkg::ST_DE;
        else status = kvp_pkg::STAT_BAD;
      end
      kvp_pkg::ST_DE: begin
        if (byte_in == kvp_pkg::CH_L) begin
          st = kvp_pkg::ST_TYPED;
          tw = 1'b1;
          tc = kvp_pkg::CODE_DEL;
        end else status = kvp_pkg::STAT_BAD;
      end
      kvp_pkg::ST_TYPED: begin
        if (eol) status = kvp_pkg::STAT_BAD;
        else if (!blank) begin
          ka = 1'b1;
          st = kvp_pkg::ST_KEY;
        end
      end
      kvp_pkg::ST_SKEY: begin
        if (eol) status = kvp_pkg::STAT_BAD;
        else if (blank) st = kvp_pkg::ST_SBLANK;
        else ka = 1'b1;
      end
      kvp_pkg::ST_SBLANK: begin
        if (eol) status = kvp_pkg::STAT_BAD;
        else if (!blank) begin
          va = 1'b1;
          st = kvp_pkg::ST_SVALUE;
        end
      end
      kvp_pkg::ST_SVALUE: begin
        if (byte_in == kvp_pkg::CH_CR) st = kvp_pkg::ST_CR;
        else va = 1'b1;
      end
      kvp_pkg::ST_KEY: begin
        if (byte_in == kvp_pkg::CH_CR) st = kvp_pkg::ST_CR;
        else ka = 1'b1;
      end
      kvp_pkg::ST_CR: begin
        status = (byte_in == kvp_pkg::CH_LF) ? kvp_pkg::STAT_GOOD : kvp_pkg::STAT_BAD;
      end
      default: begin
        // Unreachable position codes answer bad and hold.
        status = kvp_pkg::STAT_BAD;
      end
    endcase
  end

  assign state_next          = st;
  assign result.status       = status;
  assign result.type_write   = tw;
  assign result.type_code    = tc;
  assign result.key_append   = ka;
  assign result.value_append = va;
  assign result.byte_out     = (ka || va) ? byte_in : 8'h00;

endmodule

// ===== sv/kv_command_line_parser_top.sv =====
// Top level of the byte-serial key/value command line parser.
//
//   channel  | dir | payload                                  | transfer when
//   ---------+-----+------------------------------------------+-----------------------
//   in_ch    | in  | byte_in[7:0], restart                    | valid && ready
//   out_ch   | out | status[1:0], type_write, type_code[1:0], | valid && ready
//            |     | key_append, value_append, byte_out[7:0]  |
//
// Flow: one byte per cycle sustained while out_ch is not held. Each byte passes the
// input register, then the result register, before its result is offered on out_ch.
// Reset: rst (synchronous, active high) empties both stages and puts the parser
// position at the start state.
// Stalls: when out_ch is held, the result register holds, the input register fills,
// and in_ch.ready drops only once both are full.
module kv_command_line_parser_top (
  input  logic              clk,
  input  logic              rst,
  kvp_in_if.sink            in_ch,
  kvp_out_if.source         out_ch
);

  // Input register stage.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_restart;

  // Parser position, advanced as each byte moves into the result register.
  kvp_pkg::parser_state_t parser_state;
  kvp_pkg::parser_state_t parser_state_next;

  // Result register stage.
  logic                 out_valid;
  kvp_pkg::kvp_result_t out_result;
  kvp_pkg::kvp_result_t step_result;

  logic advance;
  logic in_take;

  // Move the held byte on when the result register is empty or draining now.
  assign advance = in_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !in_valid || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  kvp_step u_step (
    .state      (parser_state),
    .byte_in    (in_byte),
    .restart    (in_restart),
    .state_next (parser_state_next),
    .result     (step_result)
  );

  // Control: stage valids and parser position.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      parser_state <= kvp_pkg::ST_START;
    end else begin
      if (in_take) in_valid <= 1'b1;
      else if (advance) in_valid <= 1'b0;

      if (advance) begin
        out_valid    <= 1'b1;
        parser_state <= parser_state_next;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: capture on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte    <= in_ch.byte_in;
      in_restart <= in_ch.restart;
    end
    if (advance) out_result <= step_result;
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_result.status;
  assign out_ch.type_write   = out_result.type_write;
  assign out_ch.type_code    = out_result.type_code;
  assign out_ch.key_append   = out_result.key_append;
  assign out_ch.value_append = out_result.value_append;
  assign out_ch.byte_out     = out_result.byte_out;

endmodule
